// ===== rtl/qbsr_pkg.sv =====
// Shared types and constants for the quadratic Bezier segment rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package qbsr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ERR_BITS_DEF   = 48;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prod;
        logic orient;
        logic quad;
        logic deriv;
        logic err_init;
        logic line_setup;
        logic tick_curve;
        logic tick_line;
        logic emit_pixel;
        logic emit_bad;
    } qbsr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic bad;
        logic curv_zero;
        logic at_end;
        logic turn;
    } qbsr_status_t;

endpackage

`default_nettype wire

// ===== rtl/qbsr_ctrl.sv =====
// Controller: segment setup sequence, pixel phase and output handshake.
`timescale 1ns / 1ps
`default_nettype none

module qbsr_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   op,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    input  wire qbsr_pkg::qbsr_status_t status,
    output qbsr_pkg::qbsr_cmd_t         cmd
);
    import qbsr_pkg::*;

    typedef enum logic [6:0] {
        S_READY  = 7'b0000001,
        S_PROD   = 7'b0000010,
        S_ORIENT = 7'b0000100,
        S_QUAD   = 7'b0001000,
        S_DERIV  = 7'b0010000,
        S_ERRI   = 7'b0100000,
        S_LSETUP = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_CURVE = 3'b010,
        PH_LINE  = 3'b100
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_take, in_xfer, out_xfer;

    // Take an item only in READY with a free output slot
    assign can_take  = (state_reg == S_READY) && (!out_valid_reg || !out_stall);
    assign in_stall  = !can_take;
    assign in_xfer   = in_valid && can_take;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;

    // Sequence setup steps and pixel ticks
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        cmd            = '0;
        unique case (state_reg)
            S_READY:
            begin
                if (in_xfer)
                begin
                    if (op == OP_LOAD)
                    begin
                        cmd.capture = 1'b1;
                        phase_next  = PH_IDLE;
                        state_next  = S_PROD;
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        cmd.emit_pixel = 1'b1;
                        out_valid_next = 1'b1;
                        if (status.at_end)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (phase_reg == PH_CURVE)
                        begin
                            cmd.tick_curve = 1'b1;
                            if (status.turn)
                            begin
                                state_next = S_LSETUP;
                            end
                        end
                        else
                        begin
                            cmd.tick_line = 1'b1;
                        end
                    end
                end
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_ORIENT;
            end
            S_ORIENT:
            begin
                if (status.bad)
                begin
                    cmd.emit_bad   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_READY;
                end
                else
                begin
                    cmd.orient = 1'b1;
                    state_next = status.curv_zero ? S_LSETUP : S_QUAD;
                end
            end
            S_QUAD:
            begin
                cmd.quad   = 1'b1;
                state_next = S_DERIV;
            end
            S_DERIV:
            begin
                cmd.deriv  = 1'b1;
                state_next = S_ERRI;
            end
            S_ERRI:
            begin
                cmd.err_init = 1'b1;
                phase_next   = PH_CURVE;
                state_next   = S_READY;
            end
            S_LSETUP:
            begin
                cmd.line_setup = 1'b1;
                phase_next     = PH_LINE;
                state_next     = S_READY;
            end
            default:
            begin
                state_next = S_READY;
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_READY;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qbsr_dp.sv =====
// Datapath: setup products, forward differences, stepping and output payload.
`timescale 1ns / 1ps
`default_nettype none

module qbsr_dp #(
    parameter int COORD_BITS = qbsr_pkg::COORD_BITS_DEF,
    parameter int ERR_BITS   = qbsr_pkg::ERR_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire qbsr_pkg::qbsr_cmd_t           cmd,
    output qbsr_pkg::qbsr_status_t             status,
    input  wire logic signed [COORD_BITS-1:0]  p0_x,
    input  wire logic signed [COORD_BITS-1:0]  p0_y,
    input  wire logic signed [COORD_BITS-1:0]  p1_x,
    input  wire logic signed [COORD_BITS-1:0]  p1_y,
    input  wire logic signed [COORD_BITS-1:0]  p2_x,
    input  wire logic signed [COORD_BITS-1:0]  p2_y,
    output logic signed [COORD_BITS-1:0]       pixel_x,
    output logic signed [COORD_BITS-1:0]       pixel_y,
    output logic                               pixel_valid,
    output logic                               last_pixel,
    output logic                               bad_segment
);
    import qbsr_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int E  = ERR_BITS;
    localparam int PW = 2 * C + 2;
    localparam int TW = 3 * C + 4;

    // Captured points and differences
    logic signed [C-1:0] a_x_reg, a_y_reg, b_x_reg, b_y_reg, c_x_reg, c_y_reg;
    logic signed [C:0]   rx_reg, ry_reg, ex_reg, ey_reg;
    // First products
    logic signed [PW-1:0] rxey_reg, ryex_reg, ex2_reg, ey2_reg, rx2_reg, ry2_reg;
    // Oriented segment
    logic signed [C-1:0] cur_x_reg, cur_y_reg, end_x_reg, end_y_reg;
    logic                sx_neg_reg, sy_neg_reg;
    logic signed [PW:0]  curv_reg;
    logic signed [C+1:0] qx_reg, qy_reg;
    // Second products
    logic signed [PW+1:0] qx2_reg, qy2_reg, qxy_reg;
    logic signed [TW-1:0] t1_reg, t2_reg;
    logic                 neg_reg;
    // Differences and error
    logic signed [E-1:0] xx_reg, yy_reg, xy_reg, dx_reg, dy_reg, err_reg;
    // Output payload
    logic signed [C-1:0] px_reg, py_reg;
    logic                pv_reg, pl_reg, pb_reg;

    // Orientation logic
    logic signed [PW:0]   curv0, len_e, len_r;
    logic                 swap, sxn, syn;
    logic signed [C-1:0]  st_x, st_y, en_x, en_y;
    logic signed [C+1:0]  qsx, qsy;

    assign curv0 = PW'(rxey_reg) - PW'(ryex_reg);
    assign len_e = (PW+1)'(ex2_reg) + (PW+1)'(ey2_reg);
    assign len_r = (PW+1)'(rx2_reg) + (PW+1)'(ry2_reg);
    assign swap  = len_e > len_r;
    assign st_x  = swap ? c_x_reg : a_x_reg;
    assign st_y  = swap ? c_y_reg : a_y_reg;
    assign en_x  = swap ? a_x_reg : c_x_reg;
    assign en_y  = swap ? a_y_reg : c_y_reg;
    assign sxn   = !(st_x < en_x);
    assign syn   = !(st_y < en_y);
    assign qsx   = (C+2)'(rx_reg) + (C+2)'(ex_reg);
    assign qsy   = (C+2)'(ry_reg) + (C+2)'(ey_reg);

    // Derivative logic
    logic signed [E-1:0] qx_e, qy_e, qxy_e, m1, m2, dx_init, dy_init;
    logic                fx, fy;

    assign qx_e  = neg_reg ? -E'(qx2_reg) : E'(qx2_reg);
    assign qy_e  = neg_reg ? -E'(qy2_reg) : E'(qy2_reg);
    assign qxy_e = neg_reg ? -(E'(qxy_reg) <<< 1) : (E'(qxy_reg) <<< 1);
    assign m1    = E'(t1_reg) <<< 2;
    assign m2    = E'(t2_reg) <<< 2;
    assign fx    = sy_neg_reg ^ neg_reg;
    assign fy    = sx_neg_reg ^ neg_reg;
    assign dx_init = (fx ? -m1 : m1) + qx_e - qxy_e;
    assign dy_init = (fy ? -m2 : m2) + qy_e - qxy_e;

    // Curve step
    logic signed [E+1:0] c_edy, c_edx, c_ldy, c_ldx;
    logic                x_step, y_step, lx_step, ly_step;
    logic signed [E-1:0] dx1, dy1, err1, dx2, dy2, err2, lerr;

    assign c_edy  = ((E+2)'(err_reg) <<< 1) - (E+2)'(dy_reg);
    assign c_edx  = ((E+2)'(err_reg) <<< 1) - (E+2)'(dx_reg);
    assign x_step = c_edy > 0;
    assign y_step = c_edx < 0;
    assign dx1    = x_step ? dx_reg - xy_reg : dx_reg;
    assign dy1    = x_step ? dy_reg + yy_reg : dy_reg;
    assign err1   = x_step ? err_reg + dy1 : err_reg;
    assign dy2    = y_step ? dy1 - xy_reg : dy1;
    assign dx2    = y_step ? dx1 + xx_reg : dx1;
    assign err2   = y_step ? err1 + dx2 : err1;

    // Line step
    assign c_ldy   = c_edy;
    assign c_ldx   = c_edx;
    assign lx_step = c_ldy >= 0;
    assign ly_step = c_ldx <= 0;
    assign lerr    = err_reg + (lx_step ? dy_reg : '0) + (ly_step ? dx_reg : '0);

    // Line setup
    logic signed [C:0] lx, ly, ax_abs, ay_abs;

    assign lx     = (C+1)'(end_x_reg) - (C+1)'(cur_x_reg);
    assign ly     = (C+1)'(end_y_reg) - (C+1)'(cur_y_reg);
    assign ax_abs = lx[C] ? -lx : lx;
    assign ay_abs = ly[C] ? -ly : ly;

    // Coordinate steps
    logic signed [C-1:0] inc_x, inc_y;
    assign inc_x = sx_neg_reg ? {C{1'b1}} : C'(1);
    assign inc_y = sy_neg_reg ? {C{1'b1}} : C'(1);

    // Status to the controller
    assign status.bad = ((rx_reg != 0) && (ex_reg != 0) && (rx_reg[C] == ex_reg[C]))
                     || ((ry_reg != 0) && (ey_reg != 0) && (ry_reg[C] == ey_reg[C]));
    assign status.curv_zero = (curv0 == 0);
    assign status.at_end    = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
    assign status.turn      = !(dy2[E-1] && !dx2[E-1] && (dx2 != 0));

    // Capture points and first differences
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_x_reg <= p0_x;
            a_y_reg <= p0_y;
            b_x_reg <= p1_x;
            b_y_reg <= p1_y;
            c_x_reg <= p2_x;
            c_y_reg <= p2_y;
            rx_reg  <= (C+1)'(p0_x) - (C+1)'(p1_x);
            ry_reg  <= (C+1)'(p0_y) - (C+1)'(p1_y);
            ex_reg  <= (C+1)'(p2_x) - (C+1)'(p1_x);
            ey_reg  <= (C+1)'(p2_y) - (C+1)'(p1_y);
        end
    end

    // Form cross and square products
    always_ff @(posedge clk)
    begin
        if (cmd.prod)
        begin
            rxey_reg <= rx_reg * ey_reg;
            ryex_reg <= ry_reg * ex_reg;
            ex2_reg  <= ex_reg * ex_reg;
            ey2_reg  <= ey_reg * ey_reg;
            rx2_reg  <= rx_reg * rx_reg;
            ry2_reg  <= ry_reg * ry_reg;
        end
    end

    // Orient, then square the quadratic terms
    always_ff @(posedge clk)
    begin
        if (cmd.orient)
        begin
            curv_reg <= swap ? -curv0 : curv0;
            qx_reg   <= sxn ? -qsx : qsx;
            qy_reg   <= syn ? -qsy : qsy;
        end
        if (cmd.quad)
        begin
            qx2_reg <= qx_reg * qx_reg;
            qy2_reg <= qy_reg * qy_reg;
            qxy_reg <= qx_reg * qy_reg;
            t1_reg  <= curv_reg * ((C+1)'(b_x_reg) - (C+1)'(cur_x_reg));
            t2_reg  <= curv_reg * ((C+1)'(cur_y_reg) - (C+1)'(b_y_reg));
            neg_reg <= curv_reg[PW] ^ sx_neg_reg ^ sy_neg_reg;
        end
    end

    // Hold position, steps and differences
    always_ff @(posedge clk)
    begin
        if (cmd.orient)
        begin
            cur_x_reg  <= st_x;
            cur_y_reg  <= st_y;
            end_x_reg  <= en_x;
            end_y_reg  <= en_y;
            sx_neg_reg <= sxn;
            sy_neg_reg <= syn;
        end
        else if (cmd.line_setup)
        begin
            sx_neg_reg <= !(cur_x_reg < end_x_reg);
            sy_neg_reg <= !(cur_y_reg < end_y_reg);
            dx_reg     <= E'(ax_abs);
            dy_reg     <= -E'(ay_abs);
            err_reg    <= E'(ax_abs) - E'(ay_abs);
        end
        else if (cmd.deriv)
        begin
            xx_reg <= qx_e <<< 1;
            yy_reg <= qy_e <<< 1;
            xy_reg <= qxy_e;
            dx_reg <= dx_init;
            dy_reg <= dy_init;
        end
        else if (cmd.err_init)
        begin
            err_reg <= dx_reg + dy_reg + xy_reg;
        end
        else if (cmd.tick_curve)
        begin
            if (x_step)
            begin
                cur_x_reg <= cur_x_reg + inc_x;
            end
            if (y_step)
            begin
                cur_y_reg <= cur_y_reg + inc_y;
            end
            dx_reg  <= dx2;
            dy_reg  <= dy2;
            err_reg <= err2;
        end
        else if (cmd.tick_line)
        begin
            if (lx_step)
            begin
                cur_x_reg <= cur_x_reg + inc_x;
            end
            if (ly_step)
            begin
                cur_y_reg <= cur_y_reg + inc_y;
            end
            err_reg <= lerr;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_pixel)
        begin
            px_reg <= cur_x_reg;
            py_reg <= cur_y_reg;
            pv_reg <= 1'b1;
            pl_reg <= status.at_end;
            pb_reg <= 1'b0;
        end
        else if (cmd.emit_bad)
        begin
            px_reg <= '0;
            py_reg <= '0;
            pv_reg <= 1'b0;
            pl_reg <= 1'b0;
            pb_reg <= 1'b1;
        end
    end

    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_valid = pv_reg;
    assign last_pixel  = pl_reg;
    assign bad_segment = pb_reg;

endmodule

`default_nettype wire

// ===== rtl/quad_bezier_segment_raster_unit.sv =====
// Top level of the quadratic Bezier segment rasterizer.
//
// Input channel (in_valid / in_stall): op = load carries P0, P1, P2; op = tick asks for
// the next pixel. Output channel (out_valid / out_stall) carries one pixel per tick of an
// active segment, or one bad_segment flag for a load whose gradient changes sign.
// A load occupies the block through its setup steps (capture, products, orientation,
// squares, differences, error); a rejected segment stops after orientation, and a
// straight segment goes from orientation to line setup. When the curve turns into
// line stepping, a line setup step runs before the next item is taken. A pixel is
// presented in the cycle after its tick transfer; the bad_segment flag of a rejected
// load is presented after the products and orientation steps.
// Loads and ticks are taken while a previous result is still waiting, as long as the
// output register is free or is being taken in that cycle; otherwise in_stall rises
// and the result holds until the receiver drops out_stall.
// Reset clears the controller: no segment is active and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module quad_bezier_segment_raster_unit #(
    parameter int COORD_BITS = qbsr_pkg::COORD_BITS_DEF,
    parameter int ERR_BITS   = qbsr_pkg::ERR_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic signed [COORD_BITS-1:0]  p0_x,
    input  wire logic signed [COORD_BITS-1:0]  p0_y,
    input  wire logic signed [COORD_BITS-1:0]  p1_x,
    input  wire logic signed [COORD_BITS-1:0]  p1_y,
    input  wire logic signed [COORD_BITS-1:0]  p2_x,
    input  wire logic signed [COORD_BITS-1:0]  p2_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [COORD_BITS-1:0]       pixel_x,
    output logic signed [COORD_BITS-1:0]       pixel_y,
    output logic                               pixel_valid,
    output logic                               last_pixel,
    output logic                               bad_segment
);
    import qbsr_pkg::*;

    qbsr_cmd_t    cmd;
    qbsr_status_t status;

    qbsr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    qbsr_dp #(
        .COORD_BITS (COORD_BITS),
        .ERR_BITS   (ERR_BITS)
    ) u_dp
    (
        .clk         (clk),
        .cmd         (cmd),
        .status      (status),
        .p0_x        (p0_x),
        .p0_y        (p0_y),
        .p1_x        (p1_x),
        .p1_y        (p1_y),
        .p2_x        (p2_x),
        .p2_y        (p2_y),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_valid (pixel_valid),
        .last_pixel  (last_pixel),
        .bad_segment (bad_segment)
    );

endmodule

`default_nettype wire
